>>> sv/pld_pkg.sv
// Shared constants, codes and types for the positional list block.
`timescale 1ns / 1ps
package pld_pkg;

  localparam int DEPTH    = 16;
  localparam int ACT_W    = 2;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMP_BASE = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMP_W    = (CMP_BASE > LEN_W) ? CMP_BASE : LEN_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_DELETE = 2'd2
  } pld_action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pld_status_t;

  // Broadcast control from the decoder to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } pld_ctrl_t;

endpackage

>>> sv/pld_in_if.sv
// Request channel: action, position and word with valid/ready.
`timescale 1ns / 1ps
interface pld_in_if;
  import pld_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

>>> sv/pld_out_if.sv
// Result channel: status, removed word and new length with valid/ready.
`timescale 1ns / 1ps
interface pld_out_if;
  import pld_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] removed_value;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output status, output removed_value, output length,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input length,
                  output ready);
endinterface

>>> sv/pld_cell.sv
// One list slot: holds a word and shifts with its neighbors on insert/delete.
`timescale 1ns / 1ps
module pld_cell (
  input  logic                       clk,
  input  logic [pld_pkg::IDX_W-1:0]  cell_idx,
  input  pld_pkg::pld_ctrl_t         ctrl,
  input  logic [pld_pkg::WORD_W-1:0] new_word,
  input  logic [pld_pkg::WORD_W-1:0] lower_word,
  input  logic [pld_pkg::WORD_W-1:0] upper_word,
  input  logic [pld_pkg::WORD_W-1:0] rem_in,
  output logic [pld_pkg::WORD_W-1:0] word,
  output logic [pld_pkg::WORD_W-1:0] rem_out
);
  import pld_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [CMP_W-1:0]  idx_w;
  logic              at_pos;
  logic              past_pos;

  assign idx_w    = CMP_W'(cell_idx);
  assign at_pos   = (idx_w == ctrl.pos);
  assign past_pos = (idx_w > ctrl.pos);

  // Pick the next word: shift up from below, load, or shift down from above
  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (past_pos) begin
        word_nxt = lower_word;
      end else if (at_pos) begin
        word_nxt = new_word;
      end
    end else if (ctrl.del) begin
      if (past_pos || at_pos) begin
        word_nxt = upper_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Pass the addressed word along the removal chain
  assign rem_out = rem_in | (at_pos ? word_r : '0);
  assign word    = word_r;

endmodule

>>> sv/positional_list_insert_delete_core.sv
// Top level: request decode, row of list cells and registered result stage.
//
// Keeps an ordered list of up to DEPTH signed 32-bit words in a row of cells.
// in_ch carries one request per transaction: insert at a position, append,
// or delete at a position. out_ch returns exactly one result per request:
// status (done, position out of range, list full), the removed word (zero
// unless a delete succeeded) and the list length after the action.
// Every cell compares its own index with the request position and shifts
// in the same cycle, so the list is updated at the accepting clock edge.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle, set by the single result register;
// a new request is taken in the same cycle the pending result is taken.
// When out_ch stalls, the result holds and in_ch.ready drops until the
// result register frees up. Reset (rst_n low, synchronous) empties the
// list and drops any pending result; stored words are not cleared.
`timescale 1ns / 1ps
module positional_list_insert_delete_core (
  input  logic clk,
  input  logic rst_n,
  pld_in_if.sink    in_ch,
  pld_out_if.source out_ch
);
  import pld_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [WORD_W-1:0] removed_r;
  logic [LEN_W-1:0]  length_r;

  logic              accept;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  len_w;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  pld_status_t       status_w;
  pld_ctrl_t         ctrl;

  logic [WORD_W-1:0] entry_w [DEPTH];
  logic [WORD_W-1:0] rem_w   [DEPTH+1];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt_w = CMP_W'(count_r);
  assign full  = (cnt_w == CMP_W'(DEPTH));

  // Decode the request into a status and shift controls
  always_comb begin
    pos_w    = CMP_W'(in_ch.position);
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    status_w = ST_RANGE;
    case (in_ch.action)
      ACT_INSERT: begin
        if (pos_w > cnt_w) begin
          status_w = ST_RANGE;
        end else if (full) begin
          status_w = ST_FULL;
        end else begin
          status_w = ST_DONE;
          ins_ok   = 1'b1;
        end
      end
      ACT_APPEND: begin
        pos_w = cnt_w;
        if (full) begin
          status_w = ST_FULL;
        end else begin
          status_w = ST_DONE;
          ins_ok   = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos_w < cnt_w) begin
          status_w = ST_DONE;
          del_ok   = 1'b1;
        end
      end
      default: begin
        status_w = ST_RANGE;
      end
    endcase
  end

  assign ctrl.ins = accept && ins_ok;
  assign ctrl.del = accept && del_ok;
  assign ctrl.pos = pos_w;

  // Row of cells; the ends fold back onto themselves
  assign rem_w[0] = '0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;
    if (i == 0) begin : g_first
      assign lower_w = entry_w[i];
    end else begin : g_mid_lo
      assign lower_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper_w = entry_w[i];
    end else begin : g_mid_hi
      assign upper_w = entry_w[i+1];
    end
    pld_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .new_word   (in_ch.value),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .rem_in     (rem_w[i]),
      .word       (entry_w[i]),
      .rem_out    (rem_w[i+1])
    );
  end

  // Advance the length on a successful insert or delete
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign len_w = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_w;
      removed_r <= del_ok ? rem_w[DEPTH] : '0;
      length_r  <= len_w[LEN_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.length        = length_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("list length exceeds depth");

  a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (length_r == len_w[LEN_W-1:0]) || !accept && (CMP_W'(length_r) == cnt_w)
      || accept)
    else $error("reported length disagrees with list length");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_DONE) |-> (removed_r == '0))
    else $error("removed word nonzero on failed request");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shorten the list");
`endif

endmodule

>>> bench/tb_positional_list_insert_delete_core.sv
// Self-checking bench for the positional list: directed and random requests, scored per result.
`timescale 1ns / 1ps
module tb_positional_list_insert_delete_core;
  import pld_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 48;

  typedef struct packed {
    pld_status_t        status;
    logic [WORD_W-1:0]  removed;
    logic [LEN_W-1:0]   length;
  } list_result_t;

  // Shadow copy of the list; predicts one result per request and scores results in order
  class list_scoreboard;
    logic [WORD_W-1:0] words[DEPTH];
    int                fill;
    int                errors;
    list_result_t      expected_results[$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int length();
      return fill;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] word);
      list_result_t r;
      int at;
      r.status  = ST_RANGE;
      r.removed = '0;
      if (act == ACT_INSERT || act == ACT_APPEND) begin
        at = (act == ACT_APPEND) ? fill : int'(pos);
        // position check comes before the full check
        if (at > fill) begin
          r.status = ST_RANGE;
        end else if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = fill; i > at; i--) words[i] = words[i-1];
          words[at] = word;
          fill++;
          r.status = ST_DONE;
        end
      end else if (act == ACT_DELETE && int'(pos) < fill) begin
        r.removed = words[pos];
        for (int i = int'(pos); i + 1 < fill; i++) words[i] = words[i+1];
        fill--;
        r.status = ST_DONE;
      end
      r.length = LEN_W'(fill);
      expected_results.push_back(r);
    endfunction

    // Compare one result transaction against the oldest prediction
    function void check_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] rem,
                               logic [LEN_W-1:0] len);
      list_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d removed_value %0h length %0d",
               st, rem, len);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (rem !== want.removed) begin
        $error("removed_value mismatch: expected %0h, actual %0h", want.removed, rem);
        errors++;
      end
      if (len !== want.length) begin
        $error("length mismatch: expected %0d, actual %0d", want.length, len);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  list_scoreboard book;

  pld_in_if  in_ch ();
  pld_out_if out_ch ();

  positional_list_insert_delete_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Offer one request, hold it until taken, then maybe drop valid for a short burst
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    in_ch.value    <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_request(act, pos, word);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Mostly random words, with the extremes mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Result side: score transactions, stall in short bursts, once hold off long
  initial begin
    int hold_left;
    int results_seen;
    hold_left    = 0;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        book.check_result(out_ch.status, out_ch.removed_value, out_ch.length);
        results_seen++;
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, directed cases, random traffic, drain and report
  initial begin
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    int trend;
    int grow_pct;
    int fill;
    book = new();
    calm = 1'b0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: delete and insert past the end both miss
    send_request(ACT_DELETE, 5'd0, 32'h0);
    send_request(ACT_INSERT, 5'd1, 32'h1234_5678);
    // word extremes at the head, append ignores its position
    send_request(ACT_INSERT, 5'd0, 32'h7FFF_FFFF);
    send_request(ACT_INSERT, 5'd0, 32'h8000_0000);
    send_request(ACT_APPEND, 5'd16, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 5'd3, 32'h0);
    send_request(ACT_INSERT, 5'd1, 32'h5555_5555);
    send_request(ACT_UNKNOWN, 5'd0, 32'hAAAA_AAAA);
    // delete at the length misses; then tail, middle and head
    send_request(ACT_DELETE, 5'd5, 32'h0);
    send_request(ACT_DELETE, 5'd4, 32'h0);
    send_request(ACT_DELETE, 5'd1, 32'h0);
    send_request(ACT_DELETE, 5'd0, 32'h0);
    // fill up, then hit every full-list case
    while (book.length() < DEPTH) send_request(ACT_APPEND, 5'd0, pick_word());
    send_request(ACT_INSERT, 5'd16, 32'h0BAD_0001);
    send_request(ACT_INSERT, 5'd0, 32'h0BAD_0002);
    send_request(ACT_APPEND, 5'd0, 32'h0BAD_0003);
    send_request(ACT_DELETE, 5'd16, 32'h0);
    send_request(ACT_DELETE, 5'd15, 32'h0);
    send_request(ACT_INSERT, 5'd16, 32'h0BAD_0004);
    send_request(ACT_INSERT, 5'd15, 32'h1357_9BDF);
    send_request(ACT_DELETE, 5'd0, 32'h0);

    // random traffic in phases that grow, shrink or hold the list length
    trend = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) trend = $urandom_range(0, 2);
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      grow_pct = (trend == 0) ? 80 : (trend == 1) ? 25 : 50;
      fill = book.length();
      if ($urandom_range(0, 99) < 3) begin
        act = ACT_UNKNOWN;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        act = ($urandom_range(0, 2) == 0) ? ACT_APPEND : ACT_INSERT;
      end else begin
        act = ACT_DELETE;
      end
      if ($urandom_range(0, 9) == 0 || act == ACT_APPEND || act == ACT_UNKNOWN) begin
        pos = POS_W'($urandom_range(0, DEPTH));
      end else if (act == ACT_DELETE) begin
        pos = (fill > 0) ? POS_W'($urandom_range(0, fill - 1)) : '0;
      end else begin
        pos = POS_W'($urandom_range(0, fill));
      end
      send_request(act, pos, pick_word());
    end
    in_ch.valid <= 1'b0;

    // drain, then give the result stage a few more cycles
    while (book.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
